// File: rtl/core/edt_pkg.sv
// Package for the emoji dictionary tokenizer.
// Holds sizes, command and result types and the back-end state encoding.
// No dependencies.
package edt_pkg;

	localparam int MAX_ENTRIES     = 4096;
	localparam int MAX_PATTERN_LEN = 8;
	localparam int ENTRY_W         = $clog2(MAX_ENTRIES);
	localparam int CNT_W           = ENTRY_W + 1;
	localparam int UPOS_W          = $clog2(MAX_PATTERN_LEN);
	localparam int LEN_W           = UPOS_W + 1;
	localparam int UNIT_W          = 16;
	localparam int POS_W           = 32;
	localparam int FIFO_DEPTH      = 4;
	localparam int FIFO_AW         = $clog2(FIFO_DEPTH);
	localparam logic [5:0] LOW_SUR_TAG = 6'b110111;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_TEXT = 2'd1,
		OP_END  = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [ENTRY_W-1:0]  entry;
		logic [UPOS_W-1:0]   upos;
		logic [LEN_W-1:0]    plen;
		logic [UNIT_W-1:0]   unit;
	} cmd_t;

	typedef struct packed {
		logic                                   vld;
		logic [LEN_W-1:0]                       len;
		logic [MAX_PATTERN_LEN-1:0][UNIT_W-1:0] units;
	} row_t;

	typedef struct packed {
		logic                kind;
		logic [POS_W-1:0]    start;
		logic [POS_W-1:0]    len;
		logic [ENTRY_W-1:0]  idx;
	} result_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HEAD,
		ST_SCAN,
		ST_DRAIN,
		ST_GAP,
		ST_MATCH,
		ST_SHIFT,
		ST_TAIL,
		ST_FINISH
	} st_t;

endpackage

// File: rtl/core/edt_if.sv
// Channel interfaces of the emoji dictionary tokenizer.
// Depends on edt_pkg for field widths.
interface edt_in_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    op;
	logic [edt_pkg::ENTRY_W-1:0]   entry;
	logic [edt_pkg::UPOS_W-1:0]    unit_pos;
	logic [edt_pkg::LEN_W-1:0]     pattern_len;
	logic [edt_pkg::UNIT_W-1:0]    unit_value;
	modport source (output valid, op, entry, unit_pos, pattern_len, unit_value, input ready);
	modport sink (input valid, op, entry, unit_pos, pattern_len, unit_value, output ready);
endinterface

interface edt_out_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic [edt_pkg::POS_W-1:0]     span_start;
	logic [edt_pkg::POS_W-1:0]     span_len;
	logic [edt_pkg::ENTRY_W-1:0]   emoji_index;
	logic                          last;
	modport source (output valid, kind, span_start, span_len, emoji_index, last, input ready);
	modport sink (input valid, kind, span_start, span_len, emoji_index, last, output ready);
endinterface

// File: rtl/core/emoji_dictionary_tokenizer.sv
// Top level of the emoji dictionary tokenizer: front end, command queue, back end.
// Depends on edt_pkg, edt_if, edt_front, edt_fifo and edt_back.
//
//  channel   dir   payload
//  text_in   in    op, entry, unit_pos, pattern_len, unit_value
//  tok_out   out   kind, span_start, span_len, emoji_index, last
//
// Load item: the back end writes the table after the front register and the queue.
// Deciding a position: HEAD, SCAN and DRAIN, then GAP and MATCH on a match, then SHIFT;
// the scan reads entries 0 to the highest one loaded so far, one entry per cycle.
// Skipped or low-surrogate position: HEAD then SHIFT. End of text: each window position is
// decided in turn, then the tail span. After reset the valid marks of all 4096 entries
// are swept. A stalled output holds the back end; the front fills the queue, then stalls.
module emoji_dictionary_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	edt_in_if.sink     text_in,
	edt_out_if.source  tok_out
);
	logic          q_push, q_full, q_pop, q_empty;
	edt_pkg::cmd_t q_wdata, q_rdata;

	edt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (text_in),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	edt_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	edt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.res     (tok_out)
	);
endmodule

// File: rtl/core/edt_front.sv
// Front end: takes requests, decodes the op and holds one command for the queue.
// Depends on edt_pkg and edt_in_if.
module edt_front (
	input  logic          clk,
	input  logic          arst_n,
	edt_in_if.sink        req,
	input  logic          q_full,
	output logic          q_push,
	output edt_pkg::cmd_t q_data
);
	logic          v_s1;
	edt_pkg::cmd_t cmd_s1;
	edt_pkg::op_t  op_dec;
	logic          take;

	assign op_dec    = edt_pkg::op_t'(req.op);
	assign q_push    = v_s1 && !q_full;
	assign q_data    = cmd_s1;
	assign req.ready = !v_s1 || !q_full;
	assign take      = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= (op_dec != edt_pkg::OP_NONE);
		end else if (q_push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.op    <= op_dec;
			cmd_s1.entry <= req.entry;
			cmd_s1.upos  <= req.unit_pos;
			cmd_s1.plen  <= req.pattern_len;
			cmd_s1.unit  <= req.unit_value;
		end
	end
endmodule

// File: rtl/core/edt_fifo.sv
// Command queue between front and back ends.
// Depends on edt_pkg.
module edt_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  edt_pkg::cmd_t wdata,
	output logic          full,
	input  logic          pop,
	output edt_pkg::cmd_t rdata,
	output logic          empty
);
	edt_pkg::cmd_t                mem_q [edt_pkg::FIFO_DEPTH];
	logic [edt_pkg::FIFO_AW:0]    wp_q;
	logic [edt_pkg::FIFO_AW:0]    rp_q;

	assign empty = (wp_q == rp_q);
	assign full  = (wp_q[edt_pkg::FIFO_AW] != rp_q[edt_pkg::FIFO_AW]) &&
	               (wp_q[edt_pkg::FIFO_AW-1:0] == rp_q[edt_pkg::FIFO_AW-1:0]);
	assign rdata = mem_q[rp_q[edt_pkg::FIFO_AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push && !full) wp_q <= wp_q + 1'b1;
			if (pop && !empty) rp_q <= rp_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q[edt_pkg::FIFO_AW-1:0]] <= wdata;
	end
endmodule

// File: rtl/core/edt_back.sv
// Back end: pattern table, lookahead window, candidate scan and result output.
// Depends on edt_pkg and edt_out_if.
module edt_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  edt_pkg::cmd_t q_data,
	output logic          q_pop,
	edt_out_if.source     res
);
	localparam int ML = edt_pkg::MAX_PATTERN_LEN;

	edt_pkg::st_t st_q, st_d;
	edt_pkg::row_t mem [edt_pkg::MAX_ENTRIES];

	logic [edt_pkg::UNIT_W-1:0]  win_q [ML];
	logic [edt_pkg::LEN_W-1:0]   fill_q;
	logic [edt_pkg::POS_W-1:0]   pos_q;
	logic [edt_pkg::POS_W-1:0]   lme_q;
	logic [edt_pkg::UPOS_W-1:0]  skip_q;
	logic [edt_pkg::CNT_W-1:0]   hwm_q;
	logic [edt_pkg::CNT_W-1:0]   addr_q;
	logic                        flush_q;
	edt_pkg::row_t               row_s1;
	logic                        rd_v_s1;
	logic [edt_pkg::ENTRY_W-1:0] rd_idx_s1;
	logic [edt_pkg::LEN_W-1:0]   best_len_q;
	logic [edt_pkg::ENTRY_W-1:0] best_idx_q;
	logic                        pend_v_q;
	edt_pkg::result_t            pend_q;
	logic                        out_v_q;
	edt_pkg::result_t            out_q;
	logic                        out_last_q;

	logic                        out_free, can_push, push, sur, hit, units_eq, rd_en;
	logic                        clr_we, ld_we;
	edt_pkg::result_t            push_r;
	logic [edt_pkg::POS_W-1:0]   head_pos, gap, tail;
	logic [edt_pkg::CNT_W-1:0]   ld_end;

	assign out_free = !out_v_q || res.ready;
	assign can_push = !pend_v_q || out_free;
	assign head_pos = pos_q - edt_pkg::POS_W'(fill_q);
	assign gap      = head_pos - lme_q;
	assign tail     = pos_q - lme_q;
	assign sur      = (win_q[0][edt_pkg::UNIT_W-1 -: 6] == edt_pkg::LOW_SUR_TAG);
	assign ld_end   = {1'b0, q_data.entry} + 1'b1;
	assign rd_en    = (st_q == edt_pkg::ST_SCAN) && (addr_q != hwm_q);

	always_comb begin
		units_eq = 1'b1;
		for (int k = 0; k < ML; k++) begin
			if ((edt_pkg::LEN_W'(k) < row_s1.len) && (row_s1.units[k] != win_q[k]))
				units_eq = 1'b0;
		end
		hit = rd_v_s1 && row_s1.vld && (row_s1.len != '0) &&
		      (row_s1.len <= edt_pkg::LEN_W'(ML)) && (row_s1.len <= fill_q) &&
		      (row_s1.len > best_len_q) && units_eq;
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			edt_pkg::ST_CLEAR: begin
				if (addr_q == edt_pkg::CNT_W'(edt_pkg::MAX_ENTRIES - 1)) st_d = edt_pkg::ST_IDLE;
			end
			edt_pkg::ST_IDLE: begin
				if (!q_empty) begin
					case (q_data.op)
						edt_pkg::OP_TEXT: begin
							if (fill_q + 1'b1 >= edt_pkg::LEN_W'(ML)) st_d = edt_pkg::ST_HEAD;
						end
						edt_pkg::OP_END: st_d = edt_pkg::ST_HEAD;
						default: st_d = edt_pkg::ST_IDLE;
					endcase
				end
			end
			edt_pkg::ST_HEAD: begin
				if (fill_q == '0) st_d = edt_pkg::ST_TAIL;
				else if (skip_q != '0 || sur) st_d = edt_pkg::ST_SHIFT;
				else st_d = edt_pkg::ST_SCAN;
			end
			edt_pkg::ST_SCAN: begin
				if (addr_q == hwm_q) st_d = edt_pkg::ST_DRAIN;
			end
			edt_pkg::ST_DRAIN: st_d = (best_len_q != '0) ? edt_pkg::ST_GAP : edt_pkg::ST_SHIFT;
			edt_pkg::ST_GAP: begin
				if (gap == '0 || can_push) st_d = edt_pkg::ST_MATCH;
			end
			edt_pkg::ST_MATCH: begin
				if (can_push) st_d = edt_pkg::ST_SHIFT;
			end
			edt_pkg::ST_SHIFT: st_d = flush_q ? edt_pkg::ST_HEAD : edt_pkg::ST_FINISH;
			edt_pkg::ST_TAIL: begin
				if (tail == '0 || can_push) st_d = edt_pkg::ST_FINISH;
			end
			edt_pkg::ST_FINISH: begin
				if (!pend_v_q || out_free) st_d = edt_pkg::ST_IDLE;
			end
			default: st_d = edt_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		q_pop  = 1'b0;
		clr_we = 1'b0;
		ld_we  = 1'b0;
		push   = 1'b0;
		push_r = '0;
		case (st_q)
			edt_pkg::ST_CLEAR: clr_we = 1'b1;
			edt_pkg::ST_IDLE: begin
				q_pop = !q_empty;
				ld_we = !q_empty && (q_data.op == edt_pkg::OP_LOAD);
			end
			edt_pkg::ST_GAP: begin
				push         = (gap != '0) && can_push;
				push_r.start = lme_q;
				push_r.len   = gap;
			end
			edt_pkg::ST_MATCH: begin
				push         = can_push;
				push_r.kind  = 1'b1;
				push_r.start = head_pos;
				push_r.len   = edt_pkg::POS_W'(best_len_q);
				push_r.idx   = best_idx_q;
			end
			edt_pkg::ST_TAIL: begin
				push         = (tail != '0) && can_push;
				push_r.start = lme_q;
				push_r.len   = tail;
			end
			default: push = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (clr_we) begin
			mem[addr_q[edt_pkg::ENTRY_W-1:0]].vld <= 1'b0;
		end else if (ld_we) begin
			mem[q_data.entry].units[q_data.upos] <= q_data.unit;
			mem[q_data.entry].len                <= q_data.plen;
			mem[q_data.entry].vld                <= 1'b1;
		end
		if (rd_en) row_s1 <= mem[addr_q[edt_pkg::ENTRY_W-1:0]];
		rd_idx_s1 <= addr_q[edt_pkg::ENTRY_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= edt_pkg::ST_CLEAR;
			for (int k = 0; k < ML; k++) win_q[k] <= '0;
			fill_q     <= '0;
			pos_q      <= '0;
			lme_q      <= '0;
			skip_q     <= '0;
			hwm_q      <= '0;
			addr_q     <= '0;
			flush_q    <= 1'b0;
			rd_v_s1    <= 1'b0;
			best_len_q <= '0;
			best_idx_q <= '0;
			pend_v_q   <= 1'b0;
			pend_q     <= '0;
			out_v_q    <= 1'b0;
			out_q      <= '0;
			out_last_q <= 1'b0;
		end else begin
			st_q    <= st_d;
			rd_v_s1 <= rd_en;
			if (hit) begin
				best_len_q <= row_s1.len;
				best_idx_q <= rd_idx_s1;
			end
			if (push) begin
				if (pend_v_q) begin
					out_q      <= pend_q;
					out_last_q <= 1'b0;
					out_v_q    <= 1'b1;
				end else if (out_v_q && res.ready) begin
					out_v_q <= 1'b0;
				end
				pend_q   <= push_r;
				pend_v_q <= 1'b1;
			end else if (st_q == edt_pkg::ST_FINISH && pend_v_q && out_free) begin
				out_q      <= pend_q;
				out_last_q <= 1'b1;
				out_v_q    <= 1'b1;
				pend_v_q   <= 1'b0;
			end else if (out_v_q && res.ready) begin
				out_v_q <= 1'b0;
			end
			case (st_q)
				edt_pkg::ST_CLEAR: addr_q <= addr_q + 1'b1;
				edt_pkg::ST_IDLE: begin
					if (ld_we && ld_end > hwm_q) hwm_q <= ld_end;
					if (q_pop && q_data.op == edt_pkg::OP_TEXT) begin
						win_q[fill_q[edt_pkg::UPOS_W-1:0]] <= q_data.unit;
						fill_q  <= fill_q + 1'b1;
						pos_q   <= pos_q + 1'b1;
						flush_q <= 1'b0;
					end
					if (q_pop && q_data.op == edt_pkg::OP_END) flush_q <= 1'b1;
				end
				edt_pkg::ST_HEAD: begin
					if (fill_q != '0 && skip_q != '0) skip_q <= skip_q - 1'b1;
					addr_q     <= '0;
					best_len_q <= '0;
					best_idx_q <= '0;
				end
				edt_pkg::ST_SCAN: begin
					if (rd_en) addr_q <= addr_q + 1'b1;
				end
				edt_pkg::ST_MATCH: begin
					if (can_push) begin
						lme_q  <= head_pos + edt_pkg::POS_W'(best_len_q);
						skip_q <= edt_pkg::UPOS_W'(best_len_q - 1'b1);
					end
				end
				edt_pkg::ST_SHIFT: begin
					for (int k = 0; k < ML - 1; k++) win_q[k] <= win_q[k+1];
					win_q[ML-1] <= '0;
					fill_q      <= fill_q - 1'b1;
				end
				edt_pkg::ST_TAIL: begin
					if (tail == '0 || can_push) begin
						for (int k = 0; k < ML; k++) win_q[k] <= '0;
						fill_q  <= '0;
						pos_q   <= '0;
						lme_q   <= '0;
						skip_q  <= '0;
						flush_q <= 1'b0;
					end
				end
				default: flush_q <= flush_q;
			endcase
		end
	end

	assign res.valid       = out_v_q;
	assign res.kind        = out_q.kind;
	assign res.span_start  = out_q.start;
	assign res.span_len    = out_q.len;
	assign res.emoji_index = out_q.idx;
	assign res.last        = out_last_q;
endmodule

// File: rtl/core/edt_checker.sv
// Port-level checks on the tokenizer result channel, bound to the top level.
// Depends on edt_pkg and emoji_dictionary_tokenizer.
module edt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          kind,
	input logic [edt_pkg::POS_W-1:0]     span_start,
	input logic [edt_pkg::POS_W-1:0]     span_len,
	input logic [edt_pkg::ENTRY_W-1:0]   emoji_index,
	input logic                          last
);
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(span_start) && $stable(span_len) &&
		$stable(kind) && $stable(emoji_index) && $stable(last))
		else $error("result changed while stalled");

	a_emoji_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind |-> span_len != '0 &&
		span_len <= edt_pkg::POS_W'(edt_pkg::MAX_PATTERN_LEN))
		else $error("emoji length out of range");

	a_text_span: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kind |-> emoji_index == '0 && span_len != '0)
		else $error("bad text span");
endmodule

bind emoji_dictionary_tokenizer edt_checker u_edt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (tok_out.valid),
	.out_ready   (tok_out.ready),
	.kind        (tok_out.kind),
	.span_start  (tok_out.span_start),
	.span_len    (tok_out.span_len),
	.emoji_index (tok_out.emoji_index),
	.last        (tok_out.last)
);

// File: verif/emoji_dictionary_tokenizer_test.sv
// Testbench for emoji_dictionary_tokenizer: loads pattern tables, streams text and checks
// every token against an in-bench longest-match predictor, with random stalls on both sides.
// Depends on edt_pkg, edt_in_if/edt_out_if and the emoji_dictionary_tokenizer RTL.
`timescale 1ns / 1ps

module emoji_dictionary_tokenizer_test;

	localparam logic [15:0] SUR_LO_FIRST = 16'hDC00;
	localparam logic [15:0] SUR_LO_LAST  = 16'hDFFF;
	localparam logic [15:0] CH_A  = 16'h0041;
	localparam logic [15:0] CH_B  = 16'h0042;
	localparam logic [15:0] CH_C  = 16'h0043;
	localparam logic [15:0] SUR_HI = 16'hD83D;
	localparam logic [15:0] SUR_LO = 16'hDE00;

	typedef struct {
		bit        kind;
		bit [31:0] start;
		bit [31:0] len;
		bit [11:0] idx;
		bit        last;
	} token_t;

	logic clk;
	logic arst_n;

	edt_in_if  text_in();
	edt_out_if tok_out();

	emoji_dictionary_tokenizer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.text_in(text_in),
		.tok_out(tok_out)
	);

	bit [15:0] tbl_units[edt_pkg::MAX_ENTRIES][edt_pkg::MAX_PATTERN_LEN];
	bit [3:0]  tbl_len[edt_pkg::MAX_ENTRIES];
	bit        tbl_vld[edt_pkg::MAX_ENTRIES];
	bit [15:0] win[edt_pkg::MAX_PATTERN_LEN];
	int unsigned win_fill;
	bit [31:0] text_pos;
	bit [31:0] match_end;
	int unsigned skip_left;

	token_t step_toks[$];
	token_t token_q[$];

	int mismatches;
	int n_sent, n_loads, n_text, n_ends, n_emoji, n_spans;
	bit calm;
	bit hold_req;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("timeout with %0d tokens outstanding", token_q.size());
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int rand_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic bit [15:0] rand_unit();
		case ($urandom_range(0, 11))
			0: return CH_A;
			1: return CH_B;
			2: return CH_C;
			3: return SUR_HI;
			4: return SUR_LO;
			5: return SUR_LO_FIRST;
			6: return SUR_LO_LAST;
			7: return 16'hDBFF;
			8: return 16'hFFFF;
			9: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void add_token(bit kind, bit [31:0] start, bit [31:0] len, bit [11:0] idx);
		token_t t;
		t.kind  = kind;
		t.start = start;
		t.len   = len;
		t.idx   = idx;
		t.last  = 1'b0;
		step_toks = {step_toks, t};
	endfunction

	function automatic void decide_oldest();
		bit [31:0] head;
		int unsigned best_len;
		int unsigned best_idx;
		int unsigned plen;
		bit ok;
		if (win_fill == 0)
			return;
		head = text_pos - win_fill;
		best_len = 0;
		best_idx = 0;
		if (skip_left > 0) begin
			skip_left--;
		end else if (win[0] < SUR_LO_FIRST || win[0] > SUR_LO_LAST) begin
			for (int e = 0; e < edt_pkg::MAX_ENTRIES; e++) begin
				plen = tbl_len[e];
				if (!tbl_vld[e] || plen == 0 || plen > edt_pkg::MAX_PATTERN_LEN ||
						plen > win_fill)
					continue;
				if (plen <= best_len)
					continue;
				ok = 1'b1;
				for (int k = 0; k < plen; k++)
					if (tbl_units[e][k] != win[k])
						ok = 1'b0;
				if (ok) begin
					best_len = plen;
					best_idx = e;
				end
			end
			if (best_len > 0) begin
				if (head != match_end)
					add_token(1'b0, match_end, head - match_end, 12'd0);
				add_token(1'b1, head, best_len, best_idx[11:0]);
				match_end = head + best_len;
				skip_left = best_len - 1;
			end
		end
		for (int k = 1; k < win_fill; k++)
			win[k - 1] = win[k];
		win_fill--;
		win[win_fill] = 16'd0;
	endfunction

	function automatic void predict_request(edt_pkg::op_t op, bit [11:0] e, bit [2:0] upos,
			bit [3:0] plen, bit [15:0] unit);
		step_toks.delete();
		case (op)
			edt_pkg::OP_LOAD: begin
				tbl_units[e][upos] = unit;
				tbl_len[e] = plen;
				tbl_vld[e] = 1'b1;
				n_loads++;
			end
			edt_pkg::OP_TEXT: begin
				win[win_fill] = unit;
				win_fill++;
				text_pos++;
				n_text++;
				if (win_fill >= edt_pkg::MAX_PATTERN_LEN)
					decide_oldest();
			end
			edt_pkg::OP_END: begin
				while (win_fill > 0)
					decide_oldest();
				if (text_pos != match_end)
					add_token(1'b0, match_end, text_pos - match_end, 12'd0);
				win_fill = 0;
				text_pos = 0;
				match_end = 0;
				skip_left = 0;
				foreach (win[k])
					win[k] = 16'd0;
				n_ends++;
			end
			default: ;
		endcase
		if (step_toks.size() > 0)
			step_toks[step_toks.size() - 1].last = 1'b1;
		token_q = {token_q, step_toks};
	endfunction

	task automatic send_item(edt_pkg::op_t op, bit [11:0] e, bit [2:0] upos, bit [3:0] plen,
			bit [15:0] unit);
		int gap;
		if (!calm && $urandom_range(0, 2) == 0) begin
			gap = rand_gap();
			text_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_in.valid       <= 1'b1;
		text_in.op          <= op;
		text_in.entry       <= e;
		text_in.unit_pos    <= upos;
		text_in.pattern_len <= plen;
		text_in.unit_value  <= unit;
		do @(posedge clk); while (!text_in.ready);
		predict_request(op, e, upos, plen, unit);
		n_sent++;
	endtask

	task automatic send_text(bit [15:0] unit);
		send_item(edt_pkg::OP_TEXT, 12'($urandom), 3'($urandom), 4'($urandom), unit);
	endtask

	task automatic send_end();
		send_item(edt_pkg::OP_END, 12'($urandom), 3'($urandom), 4'($urandom), 16'($urandom));
	endtask

	// grow the length with each unit so no unwritten unit is ever inside it
	task automatic load_pattern(bit [11:0] e, int len, bit [15:0] p[8]);
		for (int k = 0; k < len; k++)
			send_item(edt_pkg::OP_LOAD, e, 3'(k), 4'(k + 1), p[k]);
	endtask

	task automatic send_entry_text(int e);
		for (int k = 0; k < tbl_len[e]; k++)
			send_text(tbl_units[e][k]);
	endtask

	always @(posedge clk) begin
		token_t want;
		if (tok_out.valid && tok_out.ready) begin
			if (token_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected token kind=%0d start=%0d len=%0d idx=%0d last=%0d",
						tok_out.kind, tok_out.span_start, tok_out.span_len,
						tok_out.emoji_index, tok_out.last);
			end else begin
				want = token_q.pop_front();
				if (want.kind) n_emoji++; else n_spans++;
				if (tok_out.kind !== want.kind || tok_out.span_start !== want.start ||
						tok_out.span_len !== want.len || tok_out.emoji_index !== want.idx ||
						tok_out.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"token mismatch: exp kind=%0d start=%0d len=%0d idx=%0d ",
							"last=%0d, got kind=%0d start=%0d len=%0d idx=%0d last=%0d"},
							want.kind, want.start, want.len, want.idx, want.last,
							tok_out.kind, tok_out.span_start, tok_out.span_len,
							tok_out.emoji_index, tok_out.last);
				end
			end
		end
	end

	initial begin
		int gap;
		tok_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				tok_out.ready <= 1'b0;
				for (int i = 0; i < 400; i++)
					@(posedge clk);
				hold_req = 1'b0;
				tok_out.ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				gap = rand_gap();
				tok_out.ready <= 1'b0;
				repeat (gap) @(posedge clk);
				tok_out.ready <= 1'b1;
			end else begin
				tok_out.ready <= 1'b1;
			end
		end
	end

	task automatic test_table_setup();
		bit [15:0] p[8];
		p = '{CH_A, 0, 0, 0, 0, 0, 0, 0};
		load_pattern(12'd0, 1, p);
		p = '{CH_A, CH_B, 0, 0, 0, 0, 0, 0};
		load_pattern(12'd1, 2, p);
		load_pattern(12'd2, 2, p);
		p = '{CH_A, CH_B, CH_A, CH_B, CH_A, CH_B, CH_A, CH_B};
		load_pattern(12'd3, 8, p);
		p = '{SUR_LO, CH_A, 0, 0, 0, 0, 0, 0};
		load_pattern(12'd4, 2, p);
		p = '{SUR_HI, SUR_LO, 0, 0, 0, 0, 0, 0};
		load_pattern(12'd5, 2, p);
		send_item(edt_pkg::OP_LOAD, 12'd6, 3'd0, 4'd0, CH_C);
		send_item(edt_pkg::OP_LOAD, 12'd7, 3'd0, 4'd15, CH_C);
	endtask

	task automatic test_basic_matching();
		for (int i = 0; i < 10; i++)
			send_text(i[0] ? CH_B : CH_A);
		send_end();
		send_text(SUR_LO);
		send_text(CH_A);
		send_text(SUR_HI);
		send_text(SUR_LO);
		send_text(CH_C);
		send_end();
	endtask

	task automatic test_empty_and_unknown();
		send_end();
		send_item(edt_pkg::OP_NONE, 12'hFFF, 3'd7, 4'hF, 16'hFFFF);
		send_text(CH_C);
		send_end();
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		calm = 1'b1;
		for (int i = 0; i < 12; i++)
			send_entry_text(1);
		send_end();
		calm = 1'b0;
	endtask

	task automatic test_random_stream(int budget);
		bit [15:0] p[8];
		int stop_at;
		int e;
		int len;
		int r;
		stop_at = n_sent + budget;
		while (n_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 3 && n_sent > stop_at - budget / 2 && !calm)
				calm = 1'b1;
			else if (r < 6)
				calm = 1'b0;
			if (r < 8) begin
				e = $urandom_range(0, 15);
				if ($urandom_range(0, 9) == 0) begin
					send_item(edt_pkg::OP_LOAD, 12'(e), 3'($urandom),
						4'($urandom_range(9, 15)), rand_unit());
				end else begin
					len = $urandom_range(1, 8);
					foreach (p[k])
						p[k] = rand_unit();
					load_pattern(12'(e), len, p);
				end
			end else if (r < 14) begin
				send_end();
			end else if (r < 17) begin
				send_item(edt_pkg::OP_NONE, 12'($urandom), 3'($urandom), 4'($urandom),
					16'($urandom));
			end else if (r < 70) begin
				e = $urandom_range(0, 15);
				if (tbl_vld[e] && tbl_len[e] >= 1 && tbl_len[e] <= edt_pkg::MAX_PATTERN_LEN)
					send_entry_text(e);
				else
					send_text(rand_unit());
			end else begin
				repeat ($urandom_range(1, 3))
					send_text(rand_unit());
			end
		end
		calm = 1'b0;
		send_end();
	endtask

	// a high entry slows every scan, so it comes last
	task automatic test_far_entry();
		bit [15:0] p[8];
		p = '{16'hFFFF, 16'h0000, 0, 0, 0, 0, 0, 0};
		load_pattern(12'hFFF, 2, p);
		send_text(16'hFFFF);
		send_text(16'h0000);
		send_text(CH_C);
		send_end();
	endtask

	initial begin
		arst_n = 1'b0;
		text_in.valid       <= 1'b0;
		text_in.op          <= edt_pkg::OP_NONE;
		text_in.entry       <= '0;
		text_in.unit_pos    <= '0;
		text_in.pattern_len <= '0;
		text_in.unit_value  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_table_setup();
		test_basic_matching();
		test_empty_and_unknown();
		test_backpressure();
		test_random_stream(230);
		test_far_entry();

		text_in.valid <= 1'b0;
		while (token_q.size() > 0)
			@(posedge clk);
		repeat (64) @(posedge clk);

		$display("covered %0d requests: %0d pattern loads, %0d text units, %0d text ends",
			n_sent, n_loads, n_text, n_ends);
		$display("checked %0d emoji tokens and %0d plain spans", n_emoji, n_spans);
		if (mismatches == 0 && token_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: emoji_dictionary_tokenizer.f
rtl/core/edt_pkg.sv
rtl/core/edt_if.sv
rtl/core/edt_front.sv
rtl/core/edt_fifo.sv
rtl/core/edt_back.sv
rtl/core/emoji_dictionary_tokenizer.sv
rtl/core/edt_checker.sv
verif/emoji_dictionary_tokenizer_test.sv
